// File: hdl/cefd_pkg.sv
package cefd_pkg;

    localparam int MAX_ROWS     = 1024;
    localparam int ROW_W        = $clog2(MAX_ROWS);
    localparam int HEIGHT_W     = 11;
    localparam int RADIUS_W     = 5;
    localparam int PIX_W        = 8;
    localparam int BRIGHT_W     = 10;
    localparam int EDGE_W       = 13;
    localparam int WIN          = 16;
    localparam int TAPS         = 7;
    localparam int MAX_FEATURES = 32;
    localparam int FIDX_W       = $clog2(MAX_FEATURES);
    localparam int FCNT_W       = FIDX_W + 1;

    localparam logic [HEIGHT_W-1:0] MIN_HEIGHT     = 11'd24;
    localparam logic [HEIGHT_W-1:0] MAX_HEIGHT     = 11'd1024;
    localparam logic [HEIGHT_W-1:0] RESET_HEIGHT   = 11'd480;
    localparam logic [RADIUS_W-1:0] MIN_RADIUS     = 5'd2;
    localparam logic [RADIUS_W-1:0] MAX_RADIUS     = 5'd16;
    localparam logic [RADIUS_W-1:0] RESET_RADIUS   = 5'd10;

    typedef enum logic {
        REG_HEIGHT = 1'b0,
        REG_RADIUS = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_LOAD = 4'b0001,
        S_EDGE = 4'b0010,
        S_NMS  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    typedef struct packed {
        logic load_en;
        logic nms_start;
        logic nms_run;
        logic emit_en;
    } t_cmd;

    typedef struct packed {
        logic pix_last;
        logic nms_done;
        logic out_last;
    } t_status;

endpackage

// File: hdl/cefd_ctrl.sv
module cefd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    input  cefd_pkg::t_status i_status,
    output cefd_pkg::t_cmd    o_cmd
);
    import cefd_pkg::*;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: if (i_in_valid && i_status.pix_last) n_state = S_EDGE;
            S_EDGE: n_state = S_NMS;
            S_NMS:  if (i_status.nms_done) n_state = S_EMIT;
            S_EMIT: if (i_out_ready && i_status.out_last) n_state = S_LOAD;
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.load_en   = (r_state == S_LOAD);
    assign o_cmd.nms_start = (r_state == S_EDGE);
    assign o_cmd.nms_run   = (r_state == S_NMS);
    assign o_cmd.emit_en   = (r_state == S_EMIT);

`ifndef SYNTHESIS
    a_edge_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EDGE) |=> (r_state == S_NMS))
        else $error("edge flush lasted more than one cycle");
    a_nms_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NMS && i_status.nms_done) |=> (r_state == S_EMIT))
        else $error("suppression end not followed by result transfer");
    a_load_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_EDGE) |-> $past(i_in_valid && i_status.pix_last))
        else $error("column closed without its last pixel");
`endif
endmodule

// File: hdl/cefd_datapath.sv
module cefd_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cefd_pkg::t_cmd                     i_cmd,
    output cefd_pkg::t_status                  o_status,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [cefd_pkg::HEIGHT_W-1:0]      i_cfg_data,
    input  logic                               i_in_valid,
    input  logic [cefd_pkg::PIX_W-1:0]         i_chan_a,
    input  logic [cefd_pkg::PIX_W-1:0]         i_chan_b,
    input  logic [cefd_pkg::PIX_W-1:0]         i_chan_c,
    input  logic                               i_out_ready,
    output logic [cefd_pkg::ROW_W-1:0]         o_feature_row,
    output logic                               o_feature_valid,
    output logic                               o_overflow,
    output logic                               o_last
);
    import cefd_pkg::*;

    logic [HEIGHT_W-1:0] r_height;
    logic [RADIUS_W-1:0] r_radius;
    logic [HEIGHT_W-1:0] h_sat;
    logic [RADIUS_W-1:0] r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= RESET_HEIGHT;
            r_radius <= RESET_RADIUS;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_HEIGHT) r_height <= i_cfg_data;
            else                           r_radius <= i_cfg_data[RADIUS_W-1:0];
        end
    end

    always_comb begin
        priority if (r_height < MIN_HEIGHT) h_sat = MIN_HEIGHT;
        else if (r_height > MAX_HEIGHT)     h_sat = MAX_HEIGHT;
        else                                h_sat = r_height;
        priority if (r_radius < MIN_RADIUS) r_sat = MIN_RADIUS;
        else if (r_radius > MAX_RADIUS)     r_sat = MAX_RADIUS;
        else                                r_sat = r_radius;
    end

    // pixel load: brightness tap line and edge strength write
    logic                load_ok;
    logic [HEIGHT_W-1:0] r_row;
    logic [BRIGHT_W-1:0] r_bw [TAPS];
    logic                r_ew_vld;
    logic [ROW_W-1:0]    r_ew_addr;
    logic                accept;
    logic [BRIGHT_W-1:0] bright;
    logic [BRIGHT_W-1:0] d1, d2, d3;
    logic [EDGE_W-1:0]   edge_val;
    logic [EDGE_W-1:0]   edge_mem [MAX_ROWS];

    assign load_ok = i_cmd.load_en;
    assign accept = i_in_valid && load_ok;
    assign bright = BRIGHT_W'(i_chan_a) + BRIGHT_W'(i_chan_b) + BRIGHT_W'(i_chan_c);
    assign o_status.pix_last = (r_row + 11'd1 == h_sat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_ew_vld <= 1'b0;
        end else begin
            r_ew_vld <= accept && (r_row >= 11'd6);
            if (i_cfg_we && i_cfg_index == REG_HEIGHT) begin
                r_row <= '0;
            end else if (accept) begin
                r_row <= o_status.pix_last ? '0 : r_row + 11'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < TAPS - 1; i++) r_bw[i] <= r_bw[i+1];
            r_bw[TAPS-1] <= bright;
            r_ew_addr    <= ROW_W'(r_row - 11'd3);
        end
    end

    always_comb begin
        d1 = (r_bw[2] > r_bw[4]) ? r_bw[2] - r_bw[4] : r_bw[4] - r_bw[2];
        d2 = (r_bw[1] > r_bw[5]) ? r_bw[1] - r_bw[5] : r_bw[5] - r_bw[1];
        d3 = (r_bw[0] > r_bw[6]) ? r_bw[0] - r_bw[6] : r_bw[6] - r_bw[0];
        edge_val = {1'b0, d1, 2'b00} + EDGE_W'(d2) + EDGE_W'(d3);
    end

    // suppression: stream edge rows through a window
    logic [HEIGHT_W-1:0] r_rd_row;
    logic [HEIGHT_W-1:0] r_q;
    logic                r_rd_vld;
    logic [EDGE_W-1:0]   r_rdata;
    logic [EDGE_W-1:0]   r_win [WIN];
    logic [EDGE_W-1:0]   in_edge;
    logic [HEIGHT_W-1:0] y;
    logic                win_full;
    logic                proc_en;
    logic                seen;
    logic [WIN-1:0]      clr;
    logic                survive;
    logic [HEIGHT_W:0]   lim_lhs, lim_rhs;

    always_ff @(posedge i_clk) begin
        if (r_ew_vld) edge_mem[r_ew_addr] <= edge_val;
        r_rdata <= edge_mem[r_rd_row[ROW_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_rd_row <= '0;
        end else if (i_cmd.nms_start) begin
            r_rd_vld <= 1'b0;
            r_rd_row <= 11'd3;
        end else if (i_cmd.nms_run) begin
            r_rd_vld <= 1'b1;
            r_rd_row <= r_rd_row + 11'd1;
        end else begin
            r_rd_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= r_rd_row;
    end

    assign in_edge  = (r_q + 11'd4 <= h_sat) ? r_rdata : '0;
    assign y        = r_q - 11'(WIN);
    assign win_full = (r_q >= 11'(WIN + 3));
    assign lim_lhs  = {1'b0, r_q} + (HEIGHT_W+1)'(r_sat) + 12'd1;
    assign lim_rhs  = {1'b0, h_sat} + 12'(WIN);
    assign proc_en  = r_rd_vld && win_full && (lim_lhs <= lim_rhs) && (r_win[0] != '0);
    assign o_status.nms_done = r_rd_vld && win_full && (lim_lhs == lim_rhs);

    always_comb begin
        seen = 1'b0;
        clr  = '0;
        for (int i = 1; i < WIN; i++) begin
            if (5'(i) < r_sat) begin
                if (r_win[i] > r_win[0]) seen = 1'b1;
                clr[i] = !seen;
            end
        end
        survive = !seen;
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            for (int i = 0; i < WIN - 1; i++) begin
                r_win[i] <= (proc_en && clr[i+1]) ? '0 : r_win[i+1];
            end
            r_win[WIN-1] <= in_edge;
        end
    end

    // feature list and result transfer
    logic [ROW_W-1:0]  r_feat [MAX_FEATURES];
    logic [FCNT_W-1:0] r_cnt;
    logic              r_drop;
    logic [FIDX_W-1:0] r_oidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_drop <= 1'b0;
            r_oidx <= '0;
        end else if (i_cmd.nms_start) begin
            r_cnt  <= '0;
            r_drop <= 1'b0;
            r_oidx <= '0;
        end else begin
            if (proc_en && survive) begin
                if (r_cnt < FCNT_W'(MAX_FEATURES)) r_cnt <= r_cnt + FCNT_W'(1);
                else                               r_drop <= 1'b1;
            end
            if (i_cmd.emit_en && i_out_ready) r_oidx <= r_oidx + FIDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_en && survive && r_cnt < FCNT_W'(MAX_FEATURES)) begin
            r_feat[r_cnt[FIDX_W-1:0]] <= y[ROW_W-1:0];
        end
    end

    assign o_feature_valid   = (r_cnt != '0);
    assign o_feature_row     = o_feature_valid ? r_feat[r_oidx] : '0;
    assign o_overflow        = r_drop;
    assign o_status.out_last = (r_cnt == '0) || ({1'b0, r_oidx} + FCNT_W'(1) == r_cnt);
    assign o_last            = o_status.out_last;

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FCNT_W'(MAX_FEATURES))
        else $error("feature count beyond list size");
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drop |-> (r_cnt == FCNT_W'(MAX_FEATURES)))
        else $error("drop flagged with room left");
    a_emit_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_en && !i_out_ready) |=> $stable(r_oidx))
        else $error("result index moved while stalled");
`endif
endmodule

// File: hdl/column_edge_feature_detector.sv
// channel  | dir | handshake                     | payload
// s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata: chan_a, chan_b, chan_c
// m_axis   | out | m_axis_tvalid / m_axis_tready | tdata: feature_row, overflow;
//          |     |                               | tuser: feature_valid; tlast: last
// cfg      | in  | i_cfg_valid / o_cfg_ready     | index 0 height, 1 radius
// Pixels are taken one per cycle while loading; edge strengths are written in the
// following cycle. After the last pixel of a column: a flush state (S_EDGE), then
// suppression at one row per cycle from the edge memory read port, then one result
// per cycle while the receiver takes them.
// No pixel is taken while suppression runs or results wait.
// Reset (synchronous, active low) restores height 480 and radius 10.
module column_edge_feature_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // chan_a[7:0], chan_b[15:8], chan_c[23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // feature_row[9:0], overflow[10], zero[15:11]
    output logic [0:0]  m_axis_tuser,   // feature_valid[0]
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [10:0] i_cfg_data
);
    import cefd_pkg::*;

    t_cmd              cmd;
    t_status           status;
    logic [ROW_W-1:0]  feature_row;
    logic              overflow;

    cefd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    cefd_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (s_axis_tvalid),
        .i_chan_a        (s_axis_tdata[7:0]),
        .i_chan_b        (s_axis_tdata[15:8]),
        .i_chan_c        (s_axis_tdata[23:16]),
        .i_out_ready     (m_axis_tready),
        .o_feature_row   (feature_row),
        .o_feature_valid (m_axis_tuser[0]),
        .o_overflow      (overflow),
        .o_last          (m_axis_tlast)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = cmd.load_en;
    assign m_axis_tvalid = cmd.emit_en;
    assign m_axis_tdata  = {5'b0, overflow, feature_row};
endmodule

// File: test/tb_column_edge_feature_detector.sv
module tb_column_edge_feature_detector;
    import cefd_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [9:0] row;
        logic       valid;
        logic       ovf;
        logic       last;
    } t_feature;

    typedef struct {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        bit         typed;
        t_feature   want;
    } t_pix_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [10:0] i_cfg_data;

    column_edge_feature_detector uut (.*);

    // shadow of the block state
    int          bright_mem [0:1023];
    int          rows_in;
    logic [10:0] height_reg;
    logic [4:0]  radius_reg;

    t_feature    feature_q [$];
    t_pix_row    dir_tab [0:23];
    int          errs;
    int          cycles;
    int          hold_cnt;
    bit          calm;
    bit          noisy;
    logic [7:0]  step_a, step_b, step_c;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int clamp(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int adiff(int x, int y);
        return (x > y) ? x - y : y - x;
    endfunction

    // edge strengths, forward suppression, then the feature list of the column
    function automatic void finish_column(bit push);
        int       h, r, n;
        bit       drop;
        int       edge_mem [0:1023];
        int       rows_found [$];
        t_feature f;
        h = clamp(height_reg, 24, 1024);
        r = clamp(radius_reg, 2, 16);
        drop = 1'b0;
        for (int y = 0; y < h; y++) begin
            if (y >= 3 && y + 4 <= h)
                edge_mem[y] = (4 * adiff(bright_mem[y-1], bright_mem[y+1])
                             + adiff(bright_mem[y-2], bright_mem[y+2])
                             + adiff(bright_mem[y-3], bright_mem[y+3])) & 13'h1fff;
            else
                edge_mem[y] = 0;
        end
        for (int y = 3; y + r + 1 <= h; y++) begin
            if (edge_mem[y] != 0) begin
                for (int y2 = y + 1; y2 < y + r; y2++) begin
                    if (edge_mem[y2] <= edge_mem[y]) begin
                        edge_mem[y2] = 0;
                    end else begin
                        edge_mem[y] = 0;
                        break;
                    end
                end
                if (edge_mem[y] != 0) begin
                    if (rows_found.size() < MAX_FEATURES) rows_found.push_back(y);
                    else drop = 1'b1;
                end
            end
        end
        rows_in = 0;
        if (!push) return;
        n = rows_found.size();
        if (n == 0) begin
            f = '{row: 10'd0, valid: 1'b0, ovf: 1'b0, last: 1'b1};
            feature_q.push_back(f);
        end
        for (int k = 0; k < n; k++) begin
            f.row   = rows_found[k][9:0];
            f.valid = 1'b1;
            f.ovf   = drop;
            f.last  = (k == n - 1);
            feature_q.push_back(f);
        end
    endfunction

    function automatic void take_pixel(logic [7:0] a, logic [7:0] b, logic [7:0] c, bit push);
        int h;
        h = clamp(height_reg, 24, 1024);
        if (rows_in >= h) rows_in = 0;
        bright_mem[rows_in] = a + b + c;
        rows_in++;
        if (rows_in >= h) finish_column(push);
    endfunction

    task automatic send_pixel(logic [7:0] a, logic [7:0] b, logic [7:0] c, bit push);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 9) begin
            gap = $urandom_range(6, 1);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {c, b, a};
        do @(posedge i_clk); while (!s_axis_tready);
        take_pixel(a, b, c, push);
    endtask

    task automatic send_random_pixel();
        if (noisy || $urandom_range(5) == 0) begin
            step_a = 8'($urandom_range(255));
            step_b = 8'($urandom_range(255));
            step_c = 8'($urandom_range(255));
        end
        send_pixel(step_a, step_b, step_c, 1'b1);
    endtask

    // drop valid and let the block settle, results and edge writes included
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (feature_q.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [10:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_HEIGHT) begin
            height_reg = value;
            rows_in    = 0;
        end else begin
            radius_reg = value[4:0];
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_column();
        int h;
        h = clamp(height_reg, 24, 1024);
        for (int i = rows_in; i < h; i++) send_random_pixel();
    endtask

    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            m_axis_tready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= 9);
        end
    end

    always @(posedge i_clk) begin
        t_feature exp_f;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (feature_q.size() == 0) begin
                $error("result transfer with nothing expected: row %0d", m_axis_tdata[9:0]);
                errs++;
            end else begin
                exp_f = feature_q.pop_front();
                if (m_axis_tdata[9:0] !== exp_f.row) begin
                    $error("feature_row expected %0d got %0d", exp_f.row, m_axis_tdata[9:0]);
                    errs++;
                end
                if (m_axis_tuser[0] !== exp_f.valid) begin
                    $error("feature_valid expected %0b got %0b", exp_f.valid, m_axis_tuser[0]);
                    errs++;
                end
                if (m_axis_tdata[10] !== exp_f.ovf) begin
                    $error("overflow expected %0b got %0b", exp_f.ovf, m_axis_tdata[10]);
                    errs++;
                end
                if (m_axis_tlast !== exp_f.last) begin
                    $error("last expected %0b got %0b", exp_f.last, m_axis_tlast);
                    errs++;
                end
            end
        end
    end

    initial begin
        t_feature none_f;
        errs = 0;
        cycles = 0;
        hold_cnt = 0;
        calm = 1'b0;
        noisy = 1'b0;
        rows_in = 0;
        height_reg = RESET_HEIGHT;
        radius_reg = RESET_RADIUS;
        step_a = 8'd0;
        step_b = 8'd0;
        step_c = 8'd0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_HEIGHT;
        i_cfg_data = '0;

        // equal brightness on every row: no edge anywhere
        none_f = '{row: 10'd0, valid: 1'b0, ovf: 1'b0, last: 1'b1};
        for (int i = 0; i < 24; i++) begin
            case (i % 3)
                0: dir_tab[i] = '{8'hff, 8'h00, 8'h00, 1'b0, none_f};
                1: dir_tab[i] = '{8'h00, 8'hff, 8'h00, 1'b0, none_f};
                default: dir_tab[i] = '{8'h00, 8'h00, 8'hff, 1'b0, none_f};
            endcase
        end
        dir_tab[23].typed = 1'b1;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // height below range saturates to 24, radius above range to 16
        write_reg(REG_HEIGHT, 11'd0);
        write_reg(REG_RADIUS, 11'd31);
        foreach (dir_tab[i]) begin
            send_pixel(dir_tab[i].a, dir_tab[i].b, dir_tab[i].c, !dir_tab[i].typed);
            if (dir_tab[i].typed) feature_q.push_back(dir_tab[i].want);
        end
        drain();

        // abandon a partial column by a height write
        for (int i = 0; i < 7; i++) send_random_pixel();
        drain();
        write_reg(REG_HEIGHT, 11'd30);
        send_column();
        drain();

        // radius change mid-column takes effect at column end
        for (int i = 0; i < 10; i++) send_random_pixel();
        drain();
        write_reg(REG_RADIUS, 11'd0);
        send_column();
        drain();

        // long receiver hold-off: results back up and the input stalls
        write_reg(REG_HEIGHT, 11'd24);
        write_reg(REG_RADIUS, 11'd16);
        hold_cnt = 700;
        for (int k = 0; k < 3; k++) send_column();
        drain();

        // tall column with a small radius and noise: overflows the feature list
        write_reg(REG_HEIGHT, 11'd128);
        write_reg(REG_RADIUS, 11'd2);
        noisy = 1'b1;
        send_column();
        noisy = 1'b0;
        drain();

        for (int k = 0; k < 4; k++) begin
            write_reg(REG_HEIGHT, ($urandom_range(3) == 0) ? 11'($urandom_range(23))
                                                           : 11'($urandom_range(40, 24)));
            write_reg(REG_RADIUS, 11'($urandom_range(31)));
            calm  = (k >= 1 && k < 3);
            noisy = ($urandom_range(2) == 0);
            send_column();
            drain();
        end
        calm = 1'b0;

        while (feature_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errs == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
